// File: rtl/core/xssp_pkg.sv
`timescale 1ns / 1ps
package xssp_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned POS_W    = 3;
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned APB_AW   = 3;

  // Register index, taken from paddr[2]
  localparam logic REG_META_WS = 1'b0;

  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_ONE   = 8'h31;
  localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;
  localparam logic [BYTE_W-1:0] CH_EQ    = 8'h3D;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_UC_A  = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UC_Z  = 8'h5A;
  localparam logic [BYTE_W-1:0] CASE_OFS = 8'h20;

  localparam logic [POS_W-1:0] MODE_LEN  = 3'd4;
  localparam logic [POS_W-1:0] BLOCK_LEN = 3'd5;

  typedef enum logic [3:0] {
    PH_FIRST   = 4'd0,
    PH_ZERO    = 4'd1,
    PH_INVALID = 4'd2,
    PH_AFTER1  = 4'd3,
    PH_AFTERSC = 4'd4,
    PH_MODE    = 4'd5,
    PH_AFTERMD = 4'd6,
    PH_AFTEREQ = 4'd7,
    PH_BLOCK   = 4'd8,
    PH_DONE    = 4'd9
  } phase_t;

  typedef struct packed {
    logic meta_ws;
  } cfg_t;

  function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] b);
    if (b >= CH_UC_A && b <= CH_UC_Z) begin
      return b + CASE_OFS;
    end
    return b;
  endfunction

  function automatic logic is_ws(input logic [BYTE_W-1:0] b, input logic meta);
    if (meta) begin
      return b <= CH_SPACE;
    end
    return (b == CH_TAB) || (b == CH_SPACE);
  endfunction

  function automatic logic [BYTE_W-1:0] mode_char(input logic [POS_W-1:0] p);
    logic [BYTE_W-1:0] c;
    case (p)
      3'd0:    c = 8'h6D; // m
      3'd1:    c = 8'h6F; // o
      3'd2:    c = 8'h64; // d
      3'd3:    c = 8'h65; // e
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [BYTE_W-1:0] block_char(input logic [POS_W-1:0] p);
    logic [BYTE_W-1:0] c;
    case (p)
      3'd0:    c = 8'h62; // b
      3'd1:    c = 8'h6C; // l
      3'd2:    c = 8'h6F; // o
      3'd3:    c = 8'h63; // c
      3'd4:    c = 8'h6B; // k
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/core/xssp_in_if.sv
`timescale 1ns / 1ps
interface xssp_in_if;
  import xssp_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] header_byte;
  logic              last_byte;
  logic              header_absent;

  modport source (output valid, header_byte, last_byte, header_absent, input ready);
  modport sink   (input valid, header_byte, last_byte, header_absent, output ready);
endinterface

// File: rtl/core/xssp_out_if.sv
`timescale 1ns / 1ps
interface xssp_out_if;
  logic valid;
  logic ready;
  logic filter_enabled;
  logic block_mode;

  modport source (output valid, filter_enabled, block_mode, input ready);
  modport sink   (input valid, filter_enabled, block_mode, output ready);
endinterface

// File: rtl/core/xssp_cfg_regs.sv
`timescale 1ns / 1ps
module xssp_cfg_regs
  import xssp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic meta_ws_r;
  logic meta_ws_nxt;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_META_WS);

  always_comb begin
    meta_ws_nxt = meta_ws_r;
    if (wr_en) begin
      meta_ws_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_ws_r <= 1'b0;
    end else begin
      meta_ws_r <= meta_ws_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_META_WS) begin
      prdata = {{(APB_DW-1){1'b0}}, meta_ws_r};
    end
  end

  assign cfg.meta_ws = meta_ws_r;

endmodule

// File: rtl/core/xssp_parser.sv
`timescale 1ns / 1ps
module xssp_parser
  import xssp_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  cfg_t   cfg,
  xssp_in_if.sink    in_ch,
  xssp_out_if.source out_ch
);

  phase_t            phase_r, phase_nxt, phase_adv;
  logic [POS_W-1:0]  pos_r, pos_nxt, pos_adv;
  logic              out_valid_r, out_valid_nxt;
  logic              filt_r, filt_nxt;
  logic              blk_r, blk_nxt;
  logic              acc;
  logic [BYTE_W-1:0] c;
  logic              ws;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign acc         = in_ch.valid && in_ch.ready;
  assign c           = fold_case(in_ch.header_byte);
  assign ws          = is_ws(in_ch.header_byte, cfg.meta_ws);

  // one-byte step of the phase machine
  always_comb begin
    phase_adv = phase_r;
    pos_adv   = pos_r;
    case (phase_r)
      PH_FIRST: begin
        if (in_ch.header_byte == CH_ZERO) phase_adv = PH_ZERO;
        else if (in_ch.header_byte == CH_ONE) phase_adv = PH_AFTER1;
        else phase_adv = PH_INVALID;
      end
      PH_ZERO: begin
        phase_adv = PH_ZERO;
      end
      PH_AFTER1: begin
        if (in_ch.header_byte == CH_SEMI) phase_adv = PH_AFTERSC;
        else if (!ws) phase_adv = PH_INVALID;
      end
      PH_AFTERSC: begin
        if (c == mode_char('0)) begin
          phase_adv = PH_MODE;
          pos_adv   = 3'd1;
        end else if (!ws) begin
          phase_adv = PH_INVALID;
        end
      end
      PH_MODE: begin
        if (pos_r < MODE_LEN && c == mode_char(pos_r)) begin
          pos_adv = pos_r + 3'd1;
          if (pos_adv == MODE_LEN) begin
            phase_adv = PH_AFTERMD;
            pos_adv   = '0;
          end
        end else begin
          phase_adv = PH_INVALID;
        end
      end
      PH_AFTERMD: begin
        if (in_ch.header_byte == CH_EQ) phase_adv = PH_AFTEREQ;
        else if (!ws) phase_adv = PH_INVALID;
      end
      PH_AFTEREQ: begin
        if (c == block_char('0)) begin
          phase_adv = PH_BLOCK;
          pos_adv   = 3'd1;
        end else if (!ws) begin
          phase_adv = PH_INVALID;
        end
      end
      PH_BLOCK: begin
        if (pos_r < BLOCK_LEN && c == block_char(pos_r)) begin
          pos_adv = pos_r + 3'd1;
          if (pos_adv == BLOCK_LEN) begin
            phase_adv = PH_DONE;
            pos_adv   = '0;
          end
        end else begin
          phase_adv = PH_INVALID;
        end
      end
      default: begin
        phase_adv = PH_INVALID;
      end
    endcase
    if (phase_adv == PH_INVALID || phase_adv == PH_ZERO) begin
      pos_adv = '0;
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    filt_nxt      = filt_r;
    blk_nxt       = blk_r;
    if (acc) begin
      if (in_ch.header_absent) begin
        phase_nxt     = PH_FIRST;
        pos_nxt       = '0;
        out_valid_nxt = 1'b1;
        filt_nxt      = 1'b1;
        blk_nxt       = 1'b0;
      end else if (in_ch.last_byte) begin
        phase_nxt     = PH_FIRST;
        pos_nxt       = '0;
        out_valid_nxt = 1'b1;
        filt_nxt      = (phase_adv != PH_ZERO);
        blk_nxt       = (phase_adv == PH_DONE);
      end else begin
        phase_nxt = phase_adv;
        pos_nxt   = pos_adv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_FIRST;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    filt_r <= filt_nxt;
    blk_r  <= blk_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.filter_enabled = filt_r;
  assign out_ch.block_mode     = blk_r;

endmodule

// File: rtl/core/xss_protection_header_parser.sv
`timescale 1ns / 1ps
// Output: a result word appears in the cycle after the word that ends a header
// (last byte or absent mark) is accepted. Throughput: one input word per cycle
// unless an untaken result holds ready low; the phase update is one case step
// and the output register reloads in the cycle its old result is taken.
// Reset (rst_n low, synchronous): phase back to first byte, output empty,
// meta_whitespace cleared.
module xss_protection_header_parser
  import xssp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  xssp_in_if.sink           in_ch,
  xssp_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  // configuration: register 0 at byte address 0
  cfg_t cfg;

  xssp_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // phase machine plus result register; words with no result just move the
  // phase, the header-ending word loads the flags
  xssp_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import xssp_pkg::*;

  localparam int LONG_HOLD  = 300;   // receiver hold-off, in cycles
  localparam int STUCK_MAX  = 3000;  // cycles with no word moving on either side
  localparam int PHASE_SIZE = 305;   // minimum input words per configuration phase
  localparam int NUM_PHASES = 6;

  localparam logic [APB_AW-1:0] META_WS_ADDR = {REG_META_WS, 2'b00};

  // One result word: the two flags of a finished header
  typedef struct packed {
    logic filter_enabled;
    logic block_mode;
  } hdr_flags_t;

  // Tracks the header parse on its own and holds the flags each finished
  // header should produce, oldest first.
  class hdr_flag_checker;
    logic             meta_ws;
    phase_t           phase;
    logic [POS_W-1:0] tok_pos;
    hdr_flags_t       pending_flags[$];
    int               errors;
    string            mode_tok;
    string            block_tok;

    function new();
      meta_ws   = 1'b0;
      errors    = 0;
      mode_tok  = "mode";
      block_tok = "block";
      restart();
    endfunction

    function void restart();
      phase   = PH_FIRST;
      tok_pos = '0;
    endfunction

    function logic blank(logic [BYTE_W-1:0] b);
      if (meta_ws) begin
        return b <= CH_SPACE;
      end
      return (b == CH_TAB) || (b == CH_SPACE);
    endfunction

    function void parse_byte(logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] c;
      c = (b >= CH_UC_A && b <= CH_UC_Z) ? b + 8'h20 : b;
      case (phase)
        PH_FIRST: begin
          if (b == CH_ZERO) phase = PH_ZERO;
          else if (b == CH_ONE) phase = PH_AFTER1;
          else phase = PH_INVALID;
        end
        PH_ZERO: begin
        end
        PH_AFTER1: begin
          if (b == CH_SEMI) phase = PH_AFTERSC;
          else if (!blank(b)) phase = PH_INVALID;
        end
        PH_AFTERSC: begin
          if (c == mode_tok[0]) begin
            phase   = PH_MODE;
            tok_pos = 3'd1;
          end else if (!blank(b)) begin
            phase = PH_INVALID;
          end
        end
        PH_MODE: begin
          if (tok_pos < MODE_LEN && c == mode_tok[tok_pos]) begin
            tok_pos++;
            if (tok_pos == MODE_LEN) begin
              phase   = PH_AFTERMD;
              tok_pos = '0;
            end
          end else begin
            phase = PH_INVALID;
          end
        end
        PH_AFTERMD: begin
          if (b == CH_EQ) phase = PH_AFTEREQ;
          else if (!blank(b)) phase = PH_INVALID;
        end
        PH_AFTEREQ: begin
          if (c == block_tok[0]) begin
            phase   = PH_BLOCK;
            tok_pos = 3'd1;
          end else if (!blank(b)) begin
            phase = PH_INVALID;
          end
        end
        PH_BLOCK: begin
          if (tok_pos < BLOCK_LEN && c == block_tok[tok_pos]) begin
            tok_pos++;
            if (tok_pos == BLOCK_LEN) begin
              phase   = PH_DONE;
              tok_pos = '0;
            end
          end else begin
            phase = PH_INVALID;
          end
        end
        default: begin
          phase = PH_INVALID;
        end
      endcase
      if (phase == PH_INVALID || phase == PH_ZERO) tok_pos = '0;
    endfunction

    function void note_word(logic [BYTE_W-1:0] b, logic last, logic absent);
      hdr_flags_t f;
      if (absent) begin
        f.filter_enabled = 1'b1;
        f.block_mode     = 1'b0;
        pending_flags.push_back(f);
        restart();
        return;
      end
      parse_byte(b);
      if (!last) return;
      f.filter_enabled = (phase != PH_ZERO);
      f.block_mode     = (phase == PH_DONE);
      pending_flags.push_back(f);
      restart();
    endfunction

    function void check_flags(logic fe, logic bm);
      hdr_flags_t f;
      if (pending_flags.size() == 0) begin
        $error("result word with nothing expected: filter_enabled %0b block_mode %0b", fe, bm);
        errors++;
        return;
      end
      f = pending_flags.pop_front();
      if (fe !== f.filter_enabled) begin
        $error("filter_enabled: expected %0b, got %0b", f.filter_enabled, fe);
        errors++;
      end
      if (bm !== f.block_mode) begin
        $error("block_mode: expected %0b, got %0b", f.block_mode, bm);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  xssp_in_if  in_ch ();
  xssp_out_if out_ch ();

  xss_protection_header_parser u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  hdr_flag_checker sb = new();

  int words_sent = 0;
  bit gaps_on    = 1'b1;  // sender gaps allowed for the current header
  bit quiet      = 1'b0;  // tail of the run: no idling on either side
  bit hold_req   = 1'b0;  // asks the receiver for one long hold-off

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Everything moving across the channels goes through the checker here.
  // Sampled at the rising edge, so the values seen are the pre-edge ones.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        sb.note_word(in_ch.header_byte, in_ch.last_byte, in_ch.header_absent);
      end
      if (out_ch.valid && out_ch.ready) begin
        sb.check_flags(out_ch.filter_enabled, out_ch.block_mode);
      end
    end
  end

  // Watchdog: too long without a word on either channel ends the run
  initial begin : watchdog
    int stuck;
    stuck = 0;
    do begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stuck = 0;
      else stuck++;
    end while (stuck < STUCK_MAX);
    $display("FAIL xss_protection_header_parser");
    $finish;
  end

  // Receiver: short random stalls, one long hold-off on request, none at the end
  initial begin : result_sink
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 4)) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // One input word; may open with a random idle gap (valid low), returns once accepted
  task automatic send_word(input logic [BYTE_W-1:0] b, input logic last,
                           input logic absent);
    @(negedge clk);
    if (gaps_on && !quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.header_byte   <= b;
    in_ch.last_byte     <= last;
    in_ch.header_absent <= absent;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_word(s[i], i == s.len() - 1, 1'b0);
    end
  endtask

  // Sender stops and waits out every pending result, then idles for the settle argument
  task automatic wait_drained(input int settle);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending_flags.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Write meta_whitespace, then read it back
  task automatic set_meta_whitespace(input logic value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= META_WS_ADDR;
    pwdata  <= APB_DW'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.meta_ws = value;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== APB_DW'(value)) begin
      $error("meta_whitespace: expected %0h, got %0h", APB_DW'(value), prdata);
      sb.errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [BYTE_W-1:0] any_blank();
    if (sb.meta_ws) return BYTE_W'($urandom_range(0, 32));
    return $urandom_range(0, 1) ? CH_TAB : CH_SPACE;
  endfunction

  function automatic void add_blanks(ref logic [BYTE_W-1:0] q[$]);
    repeat ($urandom_range(0, 2)) q.push_back(any_blank());
  endfunction

  // random upper case on letters
  function automatic logic [BYTE_W-1:0] mixed_case(input logic [BYTE_W-1:0] ch);
    if (ch >= 8'h61 && ch <= 8'h7A && $urandom_range(0, 1)) return ch - 8'h20;
    return ch;
  endfunction

  // Mostly the block form with random spacing and case, then truncated,
  // trailing, corrupted, leading zero, noise, absent and abandoned headers.
  task automatic send_random_header();
    logic [BYTE_W-1:0] q[$];
    string mode_t;
    string block_t;
    int    kind;
    bit    abandon;
    mode_t  = "mode";
    block_t = "block";
    kind    = $urandom_range(0, 99);
    abandon = 1'b0;
    gaps_on = $urandom_range(0, 2) != 0;

    q.push_back(CH_ONE);
    add_blanks(q);
    q.push_back(CH_SEMI);
    add_blanks(q);
    for (int i = 0; i < mode_t.len(); i++) q.push_back(mixed_case(mode_t[i]));
    add_blanks(q);
    q.push_back(CH_EQ);
    add_blanks(q);
    for (int i = 0; i < block_t.len(); i++) q.push_back(mixed_case(block_t[i]));

    if (kind < 35) begin
      // exact block form as built
    end else if (kind < 45) begin
      q = q[0:$urandom_range(0, q.size() - 2)];
    end else if (kind < 52) begin
      q.push_back($urandom_range(0, 1) ? any_blank() : BYTE_W'($urandom));
    end else if (kind < 65) begin
      q[$urandom_range(0, q.size() - 1)] = BYTE_W'($urandom);
    end else if (kind < 75) begin
      q = {CH_ZERO};
      repeat ($urandom_range(0, 5)) q.push_back(BYTE_W'($urandom));
    end else if (kind < 85) begin
      q = {};
      repeat ($urandom_range(1, 8)) q.push_back(BYTE_W'($urandom));
    end else if (kind < 92) begin
      send_word(BYTE_W'($urandom), 1'($urandom), 1'b1);
      return;
    end else begin
      q = q[0:$urandom_range(0, q.size() - 2)];
      abandon = 1'b1;
    end

    foreach (q[i]) send_word(q[i], !abandon && i == q.size() - 1, 1'b0);
    if (abandon) send_word(BYTE_W'($urandom), 1'($urandom), 1'b1);
  endtask

  initial begin : main
    rst_n               = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    in_ch.valid         = 1'b0;
    in_ch.header_byte   = '0;
    in_ch.last_byte     = 1'b0;
    in_ch.header_absent = 1'b0;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    set_meta_whitespace(1'b0);

    // Directed: absent header with ignored fields at max, leading zero with
    // a high tail byte, bare '0', bare '1', header abandoned by an absent mark,
    // mixed-case exact block form, bytes 00 and 80 as one-byte headers.
    send_word(8'hFF, 1'b1, 1'b1);
    send_word(CH_ZERO, 1'b0, 1'b0);
    send_word(8'hFF, 1'b1, 1'b0);
    send_text("0");
    send_text("1");
    send_word(CH_ONE, 1'b0, 1'b0);
    send_word(CH_SEMI, 1'b0, 1'b0);
    send_word(8'h00, 1'b0, 1'b1);
    send_text("1;MoDe=bLoCk");
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'h80, 1'b1, 1'b0);

    // Random phases, meta_whitespace alternating between its two values.
    // Each config write happens only after the sender has drained the block.
    for (int p = 0; p < NUM_PHASES; p++) begin
      int phase_end;
      wait_drained(4);
      set_meta_whitespace(~p[0]);
      phase_end = words_sent + PHASE_SIZE;
      if (p == 2) hold_req = 1'b1;  // long receiver hold while we keep sending
      if (p == NUM_PHASES - 1) quiet = 1'b1;
      while (words_sent < phase_end) send_random_header();
    end

    wait_drained(8);
    if (sb.errors == 0 && sb.pending_flags.size() == 0) begin
      $display("PASS xss_protection_header_parser");
    end else begin
      $display("FAIL xss_protection_header_parser");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/xssp_pkg.sv
rtl/core/xssp_in_if.sv
rtl/core/xssp_out_if.sv
rtl/core/xssp_cfg_regs.sv
rtl/core/xssp_parser.sv
rtl/core/xss_protection_header_parser.sv
tb/tb_top.sv
